FILE: hw/rtl/sfrd_pkg.sv
// sfrd_pkg: shared types, codes and constants for the sensor frame receiver
// with debounce; used by every module of the block, depends on nothing
`timescale 1ns / 1ps

package sfrd_pkg;

    // frame layout
    localparam int FRAME_LEN = 8;
    localparam int FILL_W    = $clog2(FRAME_LEN);

    localparam logic [FILL_W-1:0] POS_HUNT   = FILL_W'(0);
    localparam logic [FILL_W-1:0] POS_HEAD   = FILL_W'(1);
    localparam logic [FILL_W-1:0] POS_CMD    = FILL_W'(2);
    localparam logic [FILL_W-1:0] POS_TAIL_A = FILL_W'(6);
    localparam logic [FILL_W-1:0] POS_TAIL_B = FILL_W'(7);

    // byte codes
    localparam logic [7:0] HEAD_FIRST  = 8'h21;
    localparam logic [7:0] HEAD_SECOND = 8'h3F;
    localparam logic [7:0] TAIL_BYTE   = 8'h42;
    localparam logic [7:0] CMD_SENSOR  = 8'h01;
    localparam logic [7:0] CMD_ACK     = 8'h00;

    // result kinds
    localparam logic [1:0] KIND_SENSOR  = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    // configuration
    localparam int          INTERVAL_W     = 24;
    localparam logic [23:0] INTERVAL_RESET = 24'd500000;

    // parameter defaults
    localparam int SENSOR_LINES_DEF = 8;
    localparam int TIME_WIDTH_DEF   = 32;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic [1:0] frame_kind;
        logic [7:0] line_bits;
        logic [7:0] fired_bits;
        logic [7:0] payload_four;
        logic [7:0] payload_five;
    } t_out_item;

    // completed frame with a good tail, parser to debounce
    typedef struct packed {
        logic        done;
        logic [7:0]  cmd;
        logic [7:0]  bits;
        logic [7:0]  p4;
        logic [7:0]  p5;
        logic [31:0] now_time;
    } t_frame_evt;

endpackage

FILE: hw/rtl/sfrd_parser.sv
// sfrd_parser: header hunt, frame byte collection and tail check
// depends on sfrd_pkg
`timescale 1ns / 1ps

module sfrd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  sfrd_pkg::t_in_item  i_item,
    output sfrd_pkg::t_frame_evt o_evt
);

    logic [sfrd_pkg::FILL_W-1:0] r_fill;
    logic [sfrd_pkg::FILL_W-1:0] n_fill;
    // bytes 2..6 are kept, byte 7 is checked as it arrives
    logic [7:0] r_frame [2:6];
    logic       frame_done;
    logic [7:0] b;

    assign b = i_item.rx_byte;

    always_comb begin
        n_fill     = r_fill;
        frame_done = 1'b0;
        if (i_accept) begin
            unique case (r_fill)
                sfrd_pkg::POS_HUNT: begin
                    if (b == sfrd_pkg::HEAD_FIRST) n_fill = sfrd_pkg::POS_HEAD;
                end
                sfrd_pkg::POS_HEAD: begin
                    if (b == sfrd_pkg::HEAD_SECOND) n_fill = sfrd_pkg::POS_CMD;
                    else if (b == sfrd_pkg::HEAD_FIRST) n_fill = sfrd_pkg::POS_HEAD;
                    else n_fill = sfrd_pkg::POS_HUNT;
                end
                sfrd_pkg::POS_TAIL_B: begin
                    n_fill     = sfrd_pkg::POS_HUNT;
                    frame_done = (r_frame[6] == sfrd_pkg::TAIL_BYTE) &&
                                 (b == sfrd_pkg::TAIL_BYTE);
                end
                default: begin
                    n_fill = r_fill + 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= sfrd_pkg::POS_HUNT;
        end else begin
            r_fill <= n_fill;
        end
    end

    // body bytes, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept && r_fill >= sfrd_pkg::POS_CMD && r_fill <= sfrd_pkg::POS_TAIL_A) begin
            r_frame[r_fill] <= b;
        end
    end

    always_comb begin
        o_evt.done     = frame_done;
        o_evt.cmd      = r_frame[2];
        o_evt.bits     = r_frame[3];
        o_evt.p4       = r_frame[4];
        o_evt.p5       = r_frame[5];
        o_evt.now_time = i_item.now_time;
    end

endmodule

FILE: hw/rtl/sfrd_debounce.sv
// sfrd_debounce: rising edge detection and per-line debounce, builds the result item
// depends on sfrd_pkg
`timescale 1ns / 1ps

module sfrd_debounce #(
    parameter int SENSOR_LINES = sfrd_pkg::SENSOR_LINES_DEF,
    parameter int TIME_WIDTH   = sfrd_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sfrd_pkg::t_frame_evt                i_evt,
    input  logic [sfrd_pkg::INTERVAL_W-1:0]     i_interval,
    output logic                                o_valid,
    output sfrd_pkg::t_out_item                 o_item
);

    localparam int CMP_W = (TIME_WIDTH > sfrd_pkg::INTERVAL_W) ? TIME_WIDTH
                                                                : sfrd_pkg::INTERVAL_W;

    logic [7:0]            r_prev;
    logic [TIME_WIDTH-1:0] r_last [SENSOR_LINES];
    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed [SENSOR_LINES];
    logic [7:0]            raw;
    logic [7:0]            rise;
    logic                  is_sensor;

    assign now_t     = TIME_WIDTH'(i_evt.now_time);
    assign is_sensor = i_evt.cmd == sfrd_pkg::CMD_SENSOR;
    assign raw       = ~r_prev & i_evt.bits;

    // all lines compared in parallel, difference wraps
    always_comb begin
        rise = 8'd0;
        for (int l = 0; l < SENSOR_LINES; l++) begin
            elapsed[l] = now_t - r_last[l];
            rise[l]    = raw[l] && !(CMP_W'(elapsed[l]) < CMP_W'(i_interval));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 8'd0;
            for (int l = 0; l < SENSOR_LINES; l++) begin
                r_last[l] <= '0;
            end
        end else if (i_evt.done && is_sensor) begin
            r_prev <= i_evt.bits;
            for (int l = 0; l < SENSOR_LINES; l++) begin
                if (rise[l]) r_last[l] <= now_t;
            end
        end
    end

    always_comb begin
        o_valid             = i_evt.done;
        o_item.line_bits    = i_evt.bits;
        o_item.payload_four = i_evt.p4;
        o_item.payload_five = i_evt.p5;
        o_item.fired_bits   = 8'd0;
        if (is_sensor) begin
            o_item.frame_kind = sfrd_pkg::KIND_SENSOR;
            o_item.fired_bits = rise;
        end else if (i_evt.cmd == sfrd_pkg::CMD_ACK) begin
            o_item.frame_kind = sfrd_pkg::KIND_ACK;
        end else begin
            o_item.frame_kind = sfrd_pkg::KIND_UNKNOWN;
        end
    end

endmodule

FILE: hw/rtl/sfrd_out_queue.sv
// sfrd_out_queue: two-entry result register with skid slot
// depends on sfrd_pkg
`timescale 1ns / 1ps

module sfrd_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfrd_pkg::t_out_item i_item,
    output logic                o_full,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sfrd_pkg::t_out_item o_out_item
);

    logic [1:0]          r_count;
    logic [1:0]          n_count;
    sfrd_pkg::t_out_item r_q0;
    sfrd_pkg::t_out_item r_q1;
    logic                pop;

    assign o_full      = r_count == 2'd2;
    assign o_out_valid = r_count != 2'd0;
    assign o_out_item  = r_q0;
    assign pop         = o_out_valid && !i_out_stall;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) n_count = r_count + 2'd1;
        else if (!i_push && pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // payload slots, no reset
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_count == 2'd2) r_q0 <= r_q1;
            else if (i_push) r_q0 <= i_item;
        end else if (i_push) begin
            if (r_count == 2'd0) r_q0 <= i_item;
            else r_q1 <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue count out of range");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("result pushed into full queue");
    a_hold_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(r_q0)))
        else $error("stalled head item lost or changed");
`endif

endmodule

FILE: hw/rtl/sensor_frame_receiver_debounce_unit.sv
// sensor_frame_receiver_debounce_unit: top level of the sensor frame receiver
// depends on sfrd_pkg, sfrd_parser, sfrd_debounce, sfrd_out_queue
`timescale 1ns / 1ps

//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in_item  (rx_byte, now_time)
//  out       output     o_out_valid / i_out_stall o_out_item (kind, bits, rise, bytes 4, 5)
//  cfg       input      i_cfg_we                  i_cfg_data (debounce interval)
//
//  one byte is taken every cycle while the input is not stalled; a frame's result enters
//  the output queue on the edge that takes its last byte and is shown from the next cycle
//  the rate is set by the single fill counter step and the parallel per-line
//  debounce compares, one subtract and compare per line
//  synchronous active-low reset clears the fill counter, previous sensor bits,
//  last fire times, queue count and sets the interval to its default
//  input stalls only while both queue slots hold results

module sensor_frame_receiver_debounce_unit #(
    parameter int SENSOR_LINES = sfrd_pkg::SENSOR_LINES_DEF,
    parameter int TIME_WIDTH   = sfrd_pkg::TIME_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  sfrd_pkg::t_in_item              i_in_item,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output sfrd_pkg::t_out_item             o_out_item,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [sfrd_pkg::INTERVAL_W-1:0] i_cfg_data
);

    logic [sfrd_pkg::INTERVAL_W-1:0] r_interval;
    logic                            in_accept;
    logic                            queue_full;
    logic                            res_valid;
    sfrd_pkg::t_frame_evt            evt;
    sfrd_pkg::t_out_item             res_item;

    // debounce interval register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= sfrd_pkg::INTERVAL_RESET;
        end else if (i_cfg_we) begin
            r_interval <= i_cfg_data;
        end
    end

    // stall only when no slot is free for a possible result
    assign o_in_stall = queue_full;
    assign in_accept  = i_in_valid && !queue_full;

    // header hunt and frame collection
    sfrd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_evt    (evt)
    );

    // edge detect, debounce and result formatting
    sfrd_debounce #(
        .SENSOR_LINES (SENSOR_LINES),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_debounce (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt),
        .i_interval (r_interval),
        .o_valid    (res_valid),
        .o_item     (res_item)
    );

    // result register plus skid slot
    sfrd_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_item      (res_item),
        .o_full      (queue_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

FILE: tb/sv/sensor_frame_receiver_debounce_unit_tb.sv
// sensor_frame_receiver_debounce_unit_tb: self-checking bench for the sensor frame receiver
// depends on sfrd_pkg and sensor_frame_receiver_debounce_unit, drives byte streams with
// random idling and checks every result item against a frame parser and debounce predictor
`timescale 1ns / 1ps

module sensor_frame_receiver_debounce_unit_tb;

    localparam int  HALF_PERIOD   = 4;
    localparam int  RESET_CYCLES  = 8;
    localparam int  HOLD_CYCLES   = 120;
    localparam int  DRAIN_LIMIT   = 5000;
    localparam int  SETTLE_CYCLES = 4;
    localparam int  PHASE_ITEMS   = 90;
    localparam int  PHASES        = 5;
    localparam int  MAX_REPORTS   = 10;
    localparam time TIMEOUT_NS    = 3200000;

    localparam sfrd_pkg::t_out_item NO_RESULT = '0;

    // one row of the directed byte stream, with a typed result where obvious
    typedef struct packed {
        logic [7:0]          rx;
        logic [31:0]         stamp;
        logic                typed;
        sfrd_pkg::t_out_item want;
    } t_dir_row;

    localparam int DIR_ROWS = 36;

    t_dir_row directed_rows [DIR_ROWS] = '{
        // noise while hunting, then a broken header carrying the field extremes
        '{8'h00, 32'h0000_0000, 1'b0, NO_RESULT},
        '{sfrd_pkg::HEAD_FIRST, 32'd1, 1'b0, NO_RESULT},
        '{8'hFF, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        // repeated first header byte resyncs onto the second one
        '{sfrd_pkg::HEAD_FIRST, 32'd3, 1'b0, NO_RESULT},
        '{sfrd_pkg::HEAD_FIRST, 32'd4, 1'b0, NO_RESULT},
        '{sfrd_pkg::HEAD_SECOND, 32'd5, 1'b0, NO_RESULT},
        '{sfrd_pkg::CMD_SENSOR, 32'd6, 1'b0, NO_RESULT},
        '{8'hFF, 32'd7, 1'b0, NO_RESULT},
        '{8'h00, 32'd8, 1'b0, NO_RESULT},
        '{8'hFF, 32'd9, 1'b0, NO_RESULT},
        '{sfrd_pkg::TAIL_BYTE, 32'd10, 1'b0, NO_RESULT},
        // every line rises but the last fire times are still zero: all held back
        '{sfrd_pkg::TAIL_BYTE, 32'd100, 1'b1,
          '{sfrd_pkg::KIND_SENSOR, 8'hFF, 8'h00, 8'h00, 8'hFF}},
        // servo acknowledge
        '{sfrd_pkg::HEAD_FIRST, 32'd110, 1'b0, NO_RESULT},
        '{sfrd_pkg::HEAD_SECOND, 32'd111, 1'b0, NO_RESULT},
        '{sfrd_pkg::CMD_ACK, 32'd112, 1'b0, NO_RESULT},
        '{8'h5A, 32'd113, 1'b0, NO_RESULT},
        '{8'hA5, 32'd114, 1'b0, NO_RESULT},
        '{8'h3C, 32'd115, 1'b0, NO_RESULT},
        '{sfrd_pkg::TAIL_BYTE, 32'd116, 1'b0, NO_RESULT},
        '{sfrd_pkg::TAIL_BYTE, 32'd117, 1'b1,
          '{sfrd_pkg::KIND_ACK, 8'h5A, 8'h00, 8'hA5, 8'h3C}},
        // unknown command
        '{sfrd_pkg::HEAD_FIRST, 32'd120, 1'b0, NO_RESULT},
        '{sfrd_pkg::HEAD_SECOND, 32'd121, 1'b0, NO_RESULT},
        '{8'h7E, 32'd122, 1'b0, NO_RESULT},
        '{8'h81, 32'd123, 1'b0, NO_RESULT},
        '{8'h18, 32'd124, 1'b0, NO_RESULT},
        '{8'hE7, 32'd125, 1'b0, NO_RESULT},
        '{sfrd_pkg::TAIL_BYTE, 32'd126, 1'b0, NO_RESULT},
        '{sfrd_pkg::TAIL_BYTE, 32'd127, 1'b1,
          '{sfrd_pkg::KIND_UNKNOWN, 8'h81, 8'h00, 8'h18, 8'hE7}},
        // sensor frame with a bad last tail byte is dropped and leaves the sensor bits alone
        '{sfrd_pkg::HEAD_FIRST, 32'd130, 1'b0, NO_RESULT},
        '{sfrd_pkg::HEAD_SECOND, 32'd131, 1'b0, NO_RESULT},
        '{sfrd_pkg::CMD_SENSOR, 32'd132, 1'b0, NO_RESULT},
        '{8'h00, 32'd133, 1'b0, NO_RESULT},
        '{8'h11, 32'd134, 1'b0, NO_RESULT},
        '{8'h22, 32'd135, 1'b0, NO_RESULT},
        '{sfrd_pkg::TAIL_BYTE, 32'd136, 1'b0, NO_RESULT},
        '{8'h43, 32'd137, 1'b0, NO_RESULT}
    };

    // dut ports
    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    sfrd_pkg::t_in_item              i_in_item;
    logic                            o_out_valid;
    logic                            i_out_stall;
    sfrd_pkg::t_out_item             o_out_item;
    logic                            i_cfg_we;
    logic [sfrd_pkg::INTERVAL_W-1:0] i_cfg_data;

    // typed expectation travelling with the item on the wire
    logic                row_typed;
    sfrd_pkg::t_out_item row_want;

    // predictor state: frame assembly, previous sensor bits, per-line fire times
    int                              fill_cnt = 0;
    logic [7:0]                      rx_frame [sfrd_pkg::FRAME_LEN];
    logic [7:0]                      prior_sensors = '0;
    logic [31:0]                     line_fire_us [8] = '{default: '0};
    logic [sfrd_pkg::INTERVAL_W-1:0] debounce_us = sfrd_pkg::INTERVAL_RESET;

    sfrd_pkg::t_out_item frame_results [$];
    int                  fault_cnt = 0;

    // stimulus knobs shared with the receiver process
    int          send_idle_pct = 0;
    int          rcv_idle_pct  = 0;
    logic        hold_req      = 1'b0;
    int          items_sent    = 0;
    logic [31:0] stamp_us      = 32'd200;
    int          frame_jump    = 64;

    sensor_frame_receiver_debounce_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // one byte through the header hunt, frame fill and tail check;
    // a completed sensor frame runs the per-line debounce
    task automatic frame_parse(input sfrd_pkg::t_in_item it, output logic produced,
                               output sfrd_pkg::t_out_item res);
        logic [7:0]  b;
        logic [7:0]  edges;
        logic [7:0]  passed;
        logic [31:0] elapsed;
        b        = it.rx_byte;
        produced = 1'b0;
        res      = NO_RESULT;
        passed   = '0;
        case (fill_cnt)
            sfrd_pkg::POS_HUNT: begin
                if (b == sfrd_pkg::HEAD_FIRST) fill_cnt = 1;
            end
            sfrd_pkg::POS_HEAD: begin
                if (b == sfrd_pkg::HEAD_SECOND) fill_cnt = 2;
                else if (b == sfrd_pkg::HEAD_FIRST) fill_cnt = 1;
                else fill_cnt = 0;
            end
            default: begin
                rx_frame[fill_cnt] = b;
                fill_cnt++;
                if (fill_cnt == sfrd_pkg::FRAME_LEN) begin
                    fill_cnt = 0;
                    if (rx_frame[sfrd_pkg::POS_TAIL_A] == sfrd_pkg::TAIL_BYTE
                            && rx_frame[sfrd_pkg::POS_TAIL_B] == sfrd_pkg::TAIL_BYTE) begin
                        produced = 1'b1;
                        if (rx_frame[sfrd_pkg::POS_CMD] == sfrd_pkg::CMD_SENSOR) begin
                            edges = ~prior_sensors & rx_frame[3];
                            for (int n = 0; n < 8; n++) begin
                                // wrapping difference against the last accepted edge
                                elapsed = it.now_time - line_fire_us[n];
                                if (edges[n] && elapsed >= 32'(debounce_us)) begin
                                    line_fire_us[n] = it.now_time;
                                    passed[n]       = 1'b1;
                                end
                            end
                            prior_sensors  = rx_frame[3];
                            res.frame_kind = sfrd_pkg::KIND_SENSOR;
                        end else if (rx_frame[sfrd_pkg::POS_CMD] == sfrd_pkg::CMD_ACK) begin
                            res.frame_kind = sfrd_pkg::KIND_ACK;
                        end else begin
                            res.frame_kind = sfrd_pkg::KIND_UNKNOWN;
                        end
                        res.line_bits    = rx_frame[3];
                        res.fired_bits   = passed;
                        res.payload_four = rx_frame[4];
                        res.payload_five = rx_frame[5];
                    end
                end
            end
        endcase
    endtask

    function automatic string item_text(input sfrd_pkg::t_out_item it);
        return $sformatf("kind %0d bits %02h rise %02h b4 %02h b5 %02h", it.frame_kind,
                         it.line_bits, it.fired_bits, it.payload_four, it.payload_five);
    endfunction

    task automatic log_mismatch(input string what, input sfrd_pkg::t_out_item want,
                                input sfrd_pkg::t_out_item got);
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS)
            $display("%0t %s: expected %s, got %s", $time, what, item_text(want),
                     item_text(got));
    endtask

    // scoreboard: results are checked before the same edge's input is predicted,
    // a result never leaves in the cycle its last byte enters
    always @(posedge i_clk) begin : scoreboard
        sfrd_pkg::t_out_item want;
        sfrd_pkg::t_out_item pred;
        logic                has;
        if (i_rst_n === 1'b1) begin
            if (o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
                if (frame_results.size() == 0) begin
                    log_mismatch("unexpected result", NO_RESULT, o_out_item);
                end else begin
                    want = frame_results.pop_front();
                    if (o_out_item.frame_kind !== want.frame_kind
                            || o_out_item.line_bits !== want.line_bits
                            || o_out_item.fired_bits !== want.fired_bits
                            || o_out_item.payload_four !== want.payload_four
                            || o_out_item.payload_five !== want.payload_five)
                        log_mismatch("result mismatch", want, o_out_item);
                end
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                frame_parse(i_in_item, has, pred);
                if (row_typed) frame_results.push_back(row_want);
                else if (has) frame_results.push_back(pred);
            end
            if (i_cfg_we) debounce_us = i_cfg_data;
        end
    end

    // offer one item and hold it until taken, then maybe idle for a burst
    task automatic push_byte(input logic [7:0] b, input logic [31:0] t, input logic typed,
                             input sfrd_pkg::t_out_item want);
        i_in_valid <= 1'b1;
        i_in_item  <= '{rx_byte: b, now_time: t};
        row_typed  <= typed;
        row_want   <= want;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_sent++;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // random byte time: small steps, now and then an arbitrary jump that exercises wrap
    task automatic push_stamped(input logic [7:0] b);
        if ($urandom_range(0, 63) == 0) stamp_us = $urandom;
        else stamp_us += $urandom_range(0, 40);
        push_byte(b, stamp_us, 1'b0, NO_RESULT);
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] bits,
                              input logic [7:0] b4, input logic [7:0] b5,
                              input logic [7:0] tail_a, input logic [7:0] tail_b);
        logic [7:0] frame_bytes [sfrd_pkg::FRAME_LEN];
        frame_bytes = '{sfrd_pkg::HEAD_FIRST, sfrd_pkg::HEAD_SECOND, cmd, bits, b4, b5,
                        tail_a, tail_b};
        stamp_us += $urandom_range(0, frame_jump);
        foreach (frame_bytes[k]) push_stamped(frame_bytes[k]);
    endtask

    // stop offering and wait until every predicted result is out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        for (int w = 0; w < DRAIN_LIMIT && frame_results.size() != 0; w++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_interval(input logic [sfrd_pkg::INTERVAL_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // result side: random stall bursts, one long hold-off on request
    initial begin : receiver
        logic hold_done;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (rcv_idle_pct != 0 && $urandom_range(0, 99) < rcv_idle_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        logic [sfrd_pkg::INTERVAL_W-1:0] phase_interval [PHASES];
        int                              send_pct [PHASES];
        int                              rcv_pct [PHASES];
        int                              phase_end;
        int                              pick;
        logic [7:0]                      cmd;
        logic [7:0]                      bits;
        logic [7:0]                      bad_byte;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        row_typed  <= 1'b0;
        row_want   <= NO_RESULT;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;

        // both extremes, a short interval for the pressure phase, a random one, and back to reset
        phase_interval = '{24'd0, 24'hFF_FFFF, 24'd1000,
                           sfrd_pkg::INTERVAL_W'($urandom_range(2000, 2000000)),
                           sfrd_pkg::INTERVAL_RESET};
        send_pct = '{20, 0, 30, 10, 0};
        rcv_pct  = '{20, 0, 30, 40, 0};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed stream under the reset interval
        foreach (directed_rows[r])
            push_byte(directed_rows[r].rx, directed_rows[r].stamp, directed_rows[r].typed,
                      directed_rows[r].want);
        drain_results();

        for (int p = 0; p < PHASES; p++) begin
            write_interval(phase_interval[p]);
            frame_jump    = int'(phase_interval[p]) / 3 + 64;
            send_idle_pct = 0;
            rcv_idle_pct  = send_pct[p] == 0 ? 0 : rcv_pct[p];

            // receiver holds off while good sensor frames keep coming, filling the queue
            if (p == 2) begin
                hold_req <= 1'b1;
                repeat (6)
                    send_frame(sfrd_pkg::CMD_SENSOR, 8'($urandom), 8'($urandom),
                               8'($urandom), sfrd_pkg::TAIL_BYTE, sfrd_pkg::TAIL_BYTE);
            end
            rcv_idle_pct  = rcv_pct[p];
            send_idle_pct = send_pct[p];

            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 19))
                    0, 1:    cmd = sfrd_pkg::CMD_ACK;
                    2, 3, 4: cmd = 8'($urandom);
                    default: cmd = sfrd_pkg::CMD_SENSOR;
                endcase
                bits     = $urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom);
                bad_byte = 8'($urandom);
                if (pick < 70) begin
                    send_frame(cmd, bits, 8'($urandom), 8'($urandom), sfrd_pkg::TAIL_BYTE,
                               sfrd_pkg::TAIL_BYTE);
                end else if (pick < 80) begin
                    // one tail byte broken
                    if ($urandom_range(0, 1) == 0)
                        send_frame(cmd, bits, 8'($urandom), 8'($urandom), bad_byte,
                                   sfrd_pkg::TAIL_BYTE);
                    else
                        send_frame(cmd, bits, 8'($urandom), 8'($urandom),
                                   sfrd_pkg::TAIL_BYTE, bad_byte);
                end else if (pick < 88) begin
                    repeat ($urandom_range(1, 4)) push_stamped(8'($urandom));
                end else if (pick < 94) begin
                    // extra first header byte ahead of a good frame
                    push_stamped(sfrd_pkg::HEAD_FIRST);
                    send_frame(cmd, bits, 8'($urandom), 8'($urandom), sfrd_pkg::TAIL_BYTE,
                               sfrd_pkg::TAIL_BYTE);
                end else begin
                    push_stamped(sfrd_pkg::HEAD_FIRST);
                    push_stamped(8'($urandom));
                end
            end
            drain_results();
        end

        if (frame_results.size() != 0) begin
            fault_cnt += frame_results.size();
            $display("%0d expected results never arrived", frame_results.size());
        end
        if (fault_cnt == 0)
            $display("sensor_frame_receiver_debounce_unit_tb OK");
        else
            $display("sensor_frame_receiver_debounce_unit_tb NOT OK");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("sensor_frame_receiver_debounce_unit_tb NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/sfrd_pkg.sv
hw/rtl/sfrd_parser.sv
hw/rtl/sfrd_debounce.sv
hw/rtl/sfrd_out_queue.sv
hw/rtl/sensor_frame_receiver_debounce_unit.sv
tb/sv/sensor_frame_receiver_debounce_unit_tb.sv
